FILE: rtl/dsi_pkg.sv
// Shared types, constants and register indexes for the damped spring impulse block.
`default_nettype none
package dsi_pkg;

  localparam int unsigned QW   = 32;   // Q16.16 word
  localparam int unsigned MW   = 24;   // Q8.16 inverse mass
  localparam int unsigned TSW  = 16;   // Q0.16 time step
  localparam int unsigned DW   = 17;   // unit direction magnitude, at most 1.0
  localparam int unsigned AXES = 3;

  localparam logic [QW-1:0]  STIFFNESS_RST   = 32'd65536;
  localparam logic [QW-1:0]  DAMPING_RST     = 32'd0;
  localparam logic [QW-1:0]  REST_LENGTH_RST = 32'd65536;
  localparam logic [TSW-1:0] TIME_STEP_RST   = 16'd1092;

  typedef enum logic [1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_REST_LENGTH = 2'd2,
    CFG_TIME_STEP   = 2'd3
  } cfg_idx_t;

  // side data that rides along the length and direction units
  typedef struct packed {
    logic [AXES-1:0]         psign;
    logic [AXES-1:0][QW-1:0] vel;
    logic [MW-1:0]           m1;
    logic [MW-1:0]           m2;
  } div_tag_t;

  typedef struct packed {
    logic [AXES-1:0][QW-1:0] pmag;
    div_tag_t                side;
  } sq_tag_t;

  typedef struct packed {
    logic [AXES-1:0][QW-1:0] dvel_first;
    logic [AXES-1:0][QW-1:0] dvel_second;
    logic                    zero_length;
    logic                    saturated;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/damped_spring_impulse.sv
// Pipeline: 2 square/sum, 32 square root, 17 division and 9 force stages lie
//   between request acceptance and result valid.
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// Reset: synchronous active-low rst_n clears every stage valid bit and loads
//   the register defaults (stiffness 1.0, damping 0, rest length 1.0, step 1092).
`default_nettype none
module damped_spring_impulse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_rel_pos_x,
  input  wire logic signed [31:0] in_rel_pos_y,
  input  wire logic signed [31:0] in_rel_pos_z,
  input  wire logic signed [31:0] in_rel_vel_x,
  input  wire logic signed [31:0] in_rel_vel_y,
  input  wire logic signed [31:0] in_rel_vel_z,
  input  wire logic [23:0]        in_inv_mass_first,
  input  wire logic [23:0]        in_inv_mass_second,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_dvel_first_x,
  output logic signed [31:0]      out_dvel_first_y,
  output logic signed [31:0]      out_dvel_first_z,
  output logic signed [31:0]      out_dvel_second_x,
  output logic signed [31:0]      out_dvel_second_y,
  output logic signed [31:0]      out_dvel_second_z,
  output logic                    out_zero_length,
  output logic                    out_saturated
);
  import dsi_pkg::*;

  // configuration registers; the user must write them only while the pipe is empty (not enforced here)
  logic [QW-1:0]  stiffness_r;
  logic [QW-1:0]  damping_r;
  logic [QW-1:0]  rest_length_r;
  logic [TSW-1:0] time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r   <= STIFFNESS_RST;
      damping_r     <= DAMPING_RST;
      rest_length_r <= REST_LENGTH_RST;
      time_step_r   <= TIME_STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STIFFNESS:   stiffness_r   <= cfg_data;
        CFG_DAMPING:     damping_r     <= cfg_data;
        CFG_REST_LENGTH: rest_length_r <= cfg_data;
        CFG_TIME_STEP:   time_step_r   <= cfg_data[TSW-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances together; hold the lot while a finished result waits.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front end: take magnitudes of the position, square them, then sum.
  logic [AXES-1:0][QW-1:0] pos_in;
  logic [AXES-1:0][QW-1:0] pmag_in;
  sq_tag_t                 tag_in;

  assign pos_in = {in_rel_pos_z, in_rel_pos_y, in_rel_pos_x};

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pmag_in[i]           = pos_in[i][QW-1] ? QW'(-pos_in[i]) : pos_in[i];
      tag_in.side.psign[i] = pos_in[i][QW-1];
    end
    tag_in.pmag     = pmag_in;
    tag_in.side.vel = {in_rel_vel_z, in_rel_vel_y, in_rel_vel_x};
    tag_in.side.m1  = in_inv_mass_first;
    tag_in.side.m2  = in_inv_mass_second;
  end

  logic [AXES-1:0][63:0] sq_r;
  sq_tag_t               a_tag_r;
  logic                  a_vld_r;
  logic [63:0]           sum_r;
  sq_tag_t               b_tag_r;
  logic                  b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid && in_ready;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) sq_r[i] <= 64'(pmag_in[i]) * 64'(pmag_in[i]);
      a_tag_r <= tag_in;
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      b_tag_r <= a_tag_r;
    end
  end

  // Spring length
  logic        sq_vld;
  logic [31:0] sq_root;
  sq_tag_t     sq_tag;

  dsi_sqrt #(
    .TAG_W($bits(sq_tag_t))
  ) u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (b_vld_r),
    .in_radicand (sum_r),
    .in_tag      (b_tag_r),
    .out_valid   (sq_vld),
    .out_root    (sq_root),
    .out_tag     (sq_tag)
  );

  // Unit direction magnitudes; a zero length gives junk here, dropped later
  logic                    dv_vld;
  logic [AXES-1:0][DW-1:0] dv_quot;
  logic [QW-1:0]           dv_len;
  div_tag_t                dv_tag;

  dsi_div #(
    .TAG_W($bits(div_tag_t))
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (sq_vld),
    .in_dividend (sq_tag.pmag),
    .in_divisor  (sq_root),
    .in_tag      (sq_tag.side),
    .out_valid   (dv_vld),
    .out_quot    (dv_quot),
    .out_divisor (dv_len),
    .out_tag     (dv_tag)
  );

  // Force, impulse and clamp; its last stage is the output register
  result_t res;

  dsi_force u_force (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (dv_vld),
    .in_len      (dv_len),
    .in_dmag     (dv_quot),
    .in_tag      (dv_tag),
    .stiffness   (stiffness_r),
    .damping     (damping_r),
    .rest_length (rest_length_r),
    .time_step   (time_step_r),
    .out_valid   (out_valid),
    .out_res     (res)
  );

  assign out_dvel_first_x  = res.dvel_first[0];
  assign out_dvel_first_y  = res.dvel_first[1];
  assign out_dvel_first_z  = res.dvel_first[2];
  assign out_dvel_second_x = res.dvel_second[0];
  assign out_dvel_second_y = res.dvel_second[1];
  assign out_dvel_second_z = res.dvel_second[2];
  assign out_zero_length   = res.zero_length;
  assign out_saturated     = res.saturated;

  // A zero-length spring gives an unsaturated zero result; four of the six components are checked.
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      !out_saturated && out_dvel_first_x == 32'sd0 && out_dvel_second_x == 32'sd0 &&
      out_dvel_first_y == 32'sd0 && out_dvel_second_z == 32'sd0)
    else $error("zero-length result not cleared");

  // A clamp leaves at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_dvel_first_x == 32'sh7FFFFFFF || out_dvel_first_x == -32'sh80000000 ||
      out_dvel_first_y == 32'sh7FFFFFFF || out_dvel_first_y == -32'sh80000000 ||
      out_dvel_first_z == 32'sh7FFFFFFF || out_dvel_first_z == -32'sh80000000 ||
      out_dvel_second_x == 32'sh7FFFFFFF || out_dvel_second_x == -32'sh80000000 ||
      out_dvel_second_y == 32'sh7FFFFFFF || out_dvel_second_y == -32'sh80000000 ||
      out_dvel_second_z == 32'sh7FFFFFFF || out_dvel_second_z == -32'sh80000000)
    else $error("saturated flag without a clamped component");

  // The pipe is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && !a_vld_r && !b_vld_r)
    else $error("valid bit survived reset");

endmodule
`default_nettype wire

FILE: rtl/dsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module dsi_sqrt #(
  parameter int unsigned TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [63:0]      in_radicand,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [31:0]           out_root,
  output logic [TAG_W-1:0]      out_tag
);
  localparam int unsigned STEPS = 32;

  logic [63:0]      num_r  [STEPS];
  logic [63:0]      root_r [STEPS];
  logic             vld_r  [STEPS];
  logic [TAG_W-1:0] tag_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]      n_in;
    logic [63:0]      r_in;
    logic [63:0]      trial;
    logic             v_in;
    logic [TAG_W-1:0] t_in;

    if (k == 0) begin : g_first
      assign n_in = in_radicand;
      assign r_in = '0;
      assign v_in = in_valid;
      assign t_in = in_tag;
    end else begin : g_next
      assign n_in = num_r[k-1];
      assign r_in = root_r[k-1];
      assign v_in = vld_r[k-1];
      assign t_in = tag_r[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= t_in;
        if (n_in >= trial) begin
          num_r[k]  <= n_in - trial;
          root_r[k] <= (r_in >> 1) + BIT;
        end else begin
          num_r[k]  <= n_in;
          root_r[k] <= r_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1][31:0];
  assign out_tag   = tag_r[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/dsi_div.sv
// Pipelined three-lane restoring divider for the unit direction.
`default_nettype none
module dsi_div #(
  parameter int unsigned TAG_W = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic [dsi_pkg::AXES-1:0][dsi_pkg::QW-1:0] in_dividend,
  input  wire logic [dsi_pkg::QW-1:0]                   in_divisor,
  input  wire logic [TAG_W-1:0]                         in_tag,
  output logic                                          out_valid,
  output logic [dsi_pkg::AXES-1:0][dsi_pkg::DW-1:0]     out_quot,
  output logic [dsi_pkg::QW-1:0]                        out_divisor,
  output logic [TAG_W-1:0]                              out_tag
);
  import dsi_pkg::*;

  localparam int unsigned STEPS = DW;

  logic [AXES-1:0][QW-1:0] rem_r  [STEPS];
  logic [AXES-1:0][DW-1:0] quot_r [STEPS];
  logic [QW-1:0]           dvs_r  [STEPS];
  logic                    vld_r  [STEPS];
  logic [TAG_W-1:0]        tag_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned QB = STEPS - 1 - k;
    logic [AXES-1:0][QW-1:0] rem_in;
    logic [AXES-1:0][DW-1:0] q_in;
    logic [AXES-1:0]         low_bit;
    logic [QW-1:0]           dvs_in;
    logic                    v_in;
    logic [TAG_W-1:0]        t_in;
    logic [AXES-1:0][QW-1:0] rem_nxt;
    logic [AXES-1:0][DW-1:0] q_nxt;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < AXES; l++) begin : g_lane
        assign rem_in[l]  = {1'b0, in_dividend[l][QW-1:1]};
        assign low_bit[l] = in_dividend[l][0];
      end
      assign q_in   = '0;
      assign dvs_in = in_divisor;
      assign v_in   = in_valid;
      assign t_in   = in_tag;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign low_bit = '0;
      assign q_in    = quot_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign v_in    = vld_r[k-1];
      assign t_in    = tag_r[k-1];
    end

    for (genvar l = 0; l < AXES; l++) begin : g_calc
      logic [QW:0] shifted;
      logic        fits;
      assign shifted    = {rem_in[l], low_bit[l]};
      assign fits       = shifted >= {1'b0, dvs_in};
      assign rem_nxt[l] = fits ? QW'(shifted - {1'b0, dvs_in}) : shifted[QW-1:0];
      assign q_nxt[l]   = fits ? (q_in[l] | (DW'(1) << QB)) : q_in[l];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quot_r[k] <= q_nxt;
        dvs_r[k]  <= dvs_in;
        tag_r[k]  <= t_in;
      end
    end
  end

  assign out_valid   = vld_r[STEPS-1];
  assign out_quot    = quot_r[STEPS-1];
  assign out_divisor = dvs_r[STEPS-1];
  assign out_tag     = tag_r[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/dsi_force.sv
// Force and impulse pipeline: axial velocity, spring force, scaling and clamping.
`default_nettype none
module dsi_force (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic [dsi_pkg::QW-1:0]                   in_len,
  input  wire logic [dsi_pkg::AXES-1:0][dsi_pkg::DW-1:0] in_dmag,
  input  wire dsi_pkg::div_tag_t                        in_tag,
  input  wire logic [dsi_pkg::QW-1:0]                   stiffness,
  input  wire logic [dsi_pkg::QW-1:0]                   damping,
  input  wire logic [dsi_pkg::QW-1:0]                   rest_length,
  input  wire logic [dsi_pkg::TSW-1:0]                  time_step,
  output logic                                          out_valid,
  output dsi_pkg::result_t                              out_res
);
  import dsi_pkg::*;

  localparam int unsigned NST = 9;

  logic [NST-1:0] vld_r;

  // carried along every stage
  logic [AXES-1:0][DW-1:0] dm_r   [NST-1];
  logic [AXES-1:0]         dneg_r [NST-1];
  logic [MW-1:0]           m1_r   [NST-1];
  logic [MW-1:0]           m2_r   [NST-1];
  logic                    zero_r [NST-1];

  logic signed [49:0] pv1_r [AXES];
  logic signed [32:0] x1_r;
  logic signed [51:0] vdot2_r;
  logic [48:0]        kx_r  [3];
  logic               xneg_r [3];
  logic [33:0]        vpm3_r;
  logic               vpneg3_r;
  logic [49:0]        bv4_r;
  logic               bvneg4_r;
  logic signed [51:0] s5_r;
  logic [50:0]        fmag6_r;
  logic               fneg6_r;
  logic [50:0]        imag7_r [AXES];
  logic [AXES-1:0]    ineg7_r;
  logic [58:0]        p1_8_r  [AXES];
  logic [58:0]        p2_8_r  [AXES];
  logic [AXES-1:0]    ineg8_r;
  result_t            res_r;

  function automatic logic [QW:0] sat_word(input logic [58:0] mag, input logic neg);
    logic [QW:0] res;
    if (neg) begin
      if (mag > 59'h80000000) res = {1'b1, 32'h80000000};
      else                    res = {1'b0, QW'(-mag)};
    end else begin
      if (mag > 59'h7FFFFFFF) res = {1'b1, 32'h7FFFFFFF};
      else                    res = {1'b0, mag[QW-1:0]};
    end
    return res;
  endfunction

  // stage 1: signed direction, velocity products, stretch
  logic signed [DW:0]  d1 [AXES];
  logic signed [49:0]  pv1 [AXES];
  logic [AXES-1:0]     dneg1;
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dneg1[i] = in_tag.psign[i] && (in_dmag[i] != '0);
      d1[i]    = dneg1[i] ? -$signed({1'b0, in_dmag[i]}) : $signed({1'b0, in_dmag[i]});
      pv1[i]   = $signed(in_tag.vel[i]) * d1[i];
    end
  end

  // stage 2
  logic signed [51:0] vdot2;
  logic [32:0]        xmag2;
  logic [64:0]        kprod2;
  assign vdot2  = 52'(pv1_r[0]) + 52'(pv1_r[1]) + 52'(pv1_r[2]);
  assign xmag2  = x1_r[32] ? 33'(-x1_r) : 33'(x1_r);
  assign kprod2 = 65'(stiffness) * 65'(xmag2);

  // stage 3
  logic [51:0] vabs3;
  assign vabs3 = vdot2_r[51] ? 52'(-vdot2_r) : 52'(vdot2_r);

  // stage 4
  logic [65:0] bprod4;
  assign bprod4 = 66'(damping) * 66'(vpm3_r);

  // stage 5
  logic signed [51:0] skx5, sbv5;
  assign skx5 = $signed({3'b000, kx_r[2]});
  assign sbv5 = $signed({2'b00, bv4_r});

  // stage 6
  logic [51:0] sabs6;
  logic [66:0] fprod6;
  assign sabs6  = s5_r[51] ? 52'(-s5_r) : 52'(s5_r);
  assign fprod6 = 67'(sabs6[50:0]) * 67'(time_step);

  // stages 7 to 9 per axis
  logic [67:0] iprod7 [AXES];
  logic [74:0] mp1_8  [AXES];
  logic [74:0] mp2_8  [AXES];
  logic [QW:0] sf9    [AXES];
  logic [QW:0] ss9    [AXES];
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      iprod7[i] = 68'(fmag6_r) * 68'(dm_r[5][i]);
      mp1_8[i]  = 75'(imag7_r[i]) * 75'(m1_r[6]);
      mp2_8[i]  = 75'(imag7_r[i]) * 75'(m2_r[6]);
      sf9[i]    = sat_word(p1_8_r[i], ineg8_r[i]);
      ss9[i]    = sat_word(p2_8_r[i], !ineg8_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0]   <= in_dmag;
      dneg_r[0] <= dneg1;
      m1_r[0]   <= in_tag.m1;
      m2_r[0]   <= in_tag.m2;
      zero_r[0] <= (in_len == '0);
      for (int s = 1; s < NST - 1; s++) begin
        dm_r[s]   <= dm_r[s-1];
        dneg_r[s] <= dneg_r[s-1];
        m1_r[s]   <= m1_r[s-1];
        m2_r[s]   <= m2_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end

      for (int i = 0; i < AXES; i++) pv1_r[i] <= pv1[i];
      x1_r <= $signed({1'b0, in_len}) - $signed({1'b0, rest_length});

      vdot2_r   <= vdot2;
      kx_r[0]   <= kprod2[64:16];
      xneg_r[0] <= x1_r[32];
      kx_r[1]   <= kx_r[0];
      xneg_r[1] <= xneg_r[0];
      kx_r[2]   <= kx_r[1];
      xneg_r[2] <= xneg_r[1];

      vpm3_r   <= vabs3[49:16];
      vpneg3_r <= vdot2_r[51];

      bv4_r    <= bprod4[65:16];
      bvneg4_r <= vpneg3_r;

      s5_r <= (xneg_r[2] ? -skx5 : skx5) + (bvneg4_r ? -sbv5 : sbv5);

      fmag6_r <= fprod6[66:16];
      fneg6_r <= s5_r[51];

      for (int i = 0; i < AXES; i++) begin
        imag7_r[i] <= iprod7[i][66:16];
        ineg7_r[i] <= fneg6_r ^ dneg_r[5][i];
        p1_8_r[i]  <= mp1_8[i][74:16];
        p2_8_r[i]  <= mp2_8[i][74:16];
      end
      ineg8_r <= ineg7_r;

      res_r.zero_length <= zero_r[7];
      res_r.saturated   <= !zero_r[7] &&
                           (sf9[0][QW] || sf9[1][QW] || sf9[2][QW] ||
                            ss9[0][QW] || ss9[1][QW] || ss9[2][QW]);
      for (int i = 0; i < AXES; i++) begin
        res_r.dvel_first[i]  <= zero_r[7] ? '0 : sf9[i][QW-1:0];
        res_r.dvel_second[i] <= zero_r[7] ? '0 : ss9[i][QW-1:0];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_res   = res_r;

endmodule
`default_nettype wire
